// File: rtl/core/ibsp_pkg.sv
// Package for the indexed BMP stream parser.
// Holds the phase type, result codes, header constants and the result word type.
// No dependencies.
package ibsp_pkg;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_BODY,
        PH_DRAIN
    } phase_t;

    localparam logic [1:0] KIND_PALETTE = 2'd0;
    localparam logic [1:0] KIND_PIXEL   = 2'd1;
    localparam logic [1:0] KIND_STATUS  = 2'd2;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_FMT   = 3'd1;
    localparam logic [2:0] ST_BAD_DIMS  = 3'd2;
    localparam logic [2:0] ST_TOO_LARGE = 3'd3;
    localparam logic [2:0] ST_BAD_PAL   = 3'd4;
    localparam logic [2:0] ST_TRUNC     = 3'd5;

    localparam logic [5:0]  HDR_LAST_POS = 6'd53;
    localparam logic [32:0] HDR_BYTES    = 33'd54;
    localparam logic [32:0] POS_MAX      = 33'h1_FFFF_FFFF;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  palette_slot;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [25:0] x;
        logic [25:0] y;
        logic [7:0]  pixel_index;
        logic [2:0]  status;
        logic [26:0] image_width;
        logic [26:0] image_height;
        logic        run_last;
    } result_t;

    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

    // Header bytes with a fixed expected value: bit 8 flags a checked position.
    function automatic logic [8:0] expected_byte(input logic [5:0] pos);
        logic [8:0] e;
        e = 9'd0;
        case (pos)
            6'd0:  e = {1'b1, 8'h42};
            6'd1:  e = {1'b1, 8'h4D};
            6'd14: e = {1'b1, 8'd40};
            6'd15: e = {1'b1, 8'd0};
            6'd16: e = {1'b1, 8'd0};
            6'd17: e = {1'b1, 8'd0};
            6'd26: e = {1'b1, 8'd1};
            6'd27: e = {1'b1, 8'd0};
            6'd28: e = {1'b1, 8'd8};
            6'd29: e = {1'b1, 8'd0};
            6'd30: e = {1'b1, 8'd0};
            6'd31: e = {1'b1, 8'd0};
            6'd32: e = {1'b1, 8'd0};
            6'd33: e = {1'b1, 8'd0};
            default: e = 9'd0;
        endcase
        return e;
    endfunction

endpackage

// File: rtl/core/ibsp_in_if.sv
// Input channel of the indexed BMP stream parser: one file byte per word.
// Depends on nothing.
interface ibsp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last;

    modport source (output valid, output data_byte, output last, input ready);
    modport sink (input valid, input data_byte, input last, output ready);
endinterface

// File: rtl/core/ibsp_out_if.sv
// Output channel of the indexed BMP stream parser: one result per word.
// Depends on nothing.
interface ibsp_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  palette_slot;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [25:0] x;
    logic [25:0] y;
    logic [7:0]  pixel_index;
    logic [2:0]  status;
    logic [26:0] image_width;
    logic [26:0] image_height;
    logic        run_last;

    modport source (
        output valid, output kind, output palette_slot, output red, output green,
        output blue, output x, output y, output pixel_index, output status,
        output image_width, output image_height, output run_last, input ready
    );
    modport sink (
        input valid, input kind, input palette_slot, input red, input green,
        input blue, input x, input y, input pixel_index, input status,
        input image_width, input image_height, input run_last, output ready
    );
endinterface

// File: rtl/core/ibsp_decode.sv
// Header capture and check, palette and pixel tracking for the BMP parser.
// Produces up to two results per accepted byte. Depends on ibsp_pkg.
module ibsp_decode
    import ibsp_pkg::*;
#(
    parameter int MAX_PIXELS      = 67108864,
    parameter int PALETTE_ENTRIES = 256
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] data_byte,
    input  logic       last,
    output push_t      push
);

    localparam int CNT_W = $clog2(MAX_PIXELS + 4);

    phase_t             phase_reg, phase_next;
    logic [32:0]        pos_reg, pos_next;
    logic [31:0]        width_reg, width_next;
    logic [31:0]        height_reg, height_next;
    logic [31:0]        offset_reg, offset_next;
    logic [31:0]        colors_reg, colors_next;
    logic               fmt_good_reg, fmt_good_next;
    logic [7:0]         held_blue_reg, held_blue_next;
    logic [7:0]         held_green_reg, held_green_next;
    logic [CNT_W-1:0]   row_reg, row_next;
    logic [CNT_W-1:0]   col_reg, col_next;

    logic [31:0]        hm_reg;
    logic [63:0]        product_reg;
    logic [31:0]        pc_reg;
    logic [34:0]        pal_end_reg;
    logic [32:0]        pitch_reg;

    logic [31:0]        pc_now;
    logic [5:0]         hp;
    logic [5:0]         hp_off;
    logic [4:0]         sh;
    logic [8:0]         exp_b;
    logic [2:0]         judge;
    logic               in_palette;
    logic               in_pixels;
    logic [32:0]        rel;
    logic [CNT_W:0]     col_inc;
    logic [31:0]        y_val;
    logic               file_end;
    result_t            status_res;
    result_t            data_res;
    logic               data_valid;

    assign hp     = pos_reg[5:0];
    assign hp_off = hp - 6'd10;
    assign sh     = {hp_off[1:0], 3'b000};
    assign exp_b  = expected_byte(hp);
    assign pc_now = (colors_reg != 32'd0) ? colors_reg : 32'(PALETTE_ENTRIES);

    // Derived header quantities, settled long before the header check at byte 53.
    always_ff @(posedge clk)
    begin
        hm_reg      <= height_reg[31] ? (~height_reg + 32'd1) : height_reg;
        product_reg <= {32'd0, width_reg} * {32'd0, hm_reg};
        pc_reg      <= pc_now;
        pal_end_reg <= {1'b0, pc_now, 2'b00} + 35'd54;
        pitch_reg   <= ({1'b0, width_reg} + 33'd3) & ~33'd3;
    end

    always_comb
    begin
        judge = ST_OK;
        if (!fmt_good_reg)
        begin
            judge = ST_BAD_FMT;
        end
        else if (width_reg == 32'd0 || width_reg[31] || height_reg == 32'd0 ||
                 height_reg == 32'h8000_0000)
        begin
            judge = ST_BAD_DIMS;
        end
        else if (product_reg > 64'(MAX_PIXELS))
        begin
            judge = ST_TOO_LARGE;
        end
        else if (pc_reg > 32'(PALETTE_ENTRIES) || {3'd0, offset_reg} < pal_end_reg)
        begin
            judge = ST_BAD_PAL;
        end
    end

    assign rel        = pos_reg - HDR_BYTES;
    assign in_palette = (pos_reg >= HDR_BYTES) && ({2'd0, pos_reg} < pal_end_reg);
    assign in_pixels  = (pos_reg >= {1'b0, offset_reg}) &&
                        ({{(32 - CNT_W){1'b0}}, row_reg} < hm_reg);
    assign col_inc    = {1'b0, col_reg} + {{CNT_W{1'b0}}, 1'b1};
    assign y_val      = height_reg[31] ? 32'(row_reg)
                                       : (hm_reg - 32'd1 - 32'(row_reg));

    always_comb
    begin
        phase_next = phase_reg;
        case (phase_reg)
            PH_HEADER:
            begin
                if (hp == HDR_LAST_POS)
                begin
                    phase_next = (judge != ST_OK) ? PH_DRAIN : PH_BODY;
                end
                if (last)
                begin
                    phase_next = PH_HEADER;
                end
            end
            PH_BODY:
            begin
                if (last)
                begin
                    phase_next = PH_HEADER;
                end
            end
            PH_DRAIN:
            begin
                if (last)
                begin
                    phase_next = PH_HEADER;
                end
            end
            default: phase_next = PH_HEADER;
        endcase
    end

    always_comb
    begin
        pos_next        = pos_reg;
        width_next      = width_reg;
        height_next     = height_reg;
        offset_next     = offset_reg;
        colors_next     = colors_reg;
        fmt_good_next   = fmt_good_reg;
        held_blue_next  = held_blue_reg;
        held_green_next = held_green_reg;
        row_next        = row_reg;
        col_next        = col_reg;
        status_res      = '0;
        data_res        = '0;
        data_valid      = 1'b0;
        file_end        = last;
        push            = '0;

        status_res.kind         = KIND_STATUS;
        status_res.image_width  = width_reg[26:0];
        status_res.image_height = hm_reg[26:0];
        status_res.run_last     = 1'b1;

        case (phase_reg)
            PH_HEADER:
            begin
                if (exp_b[8] && data_byte != exp_b[7:0])
                begin
                    fmt_good_next = 1'b0;
                end
                if (hp >= 6'd10 && hp <= 6'd13)
                begin
                    offset_next[sh +: 8] = data_byte;
                end
                if (hp >= 6'd18 && hp <= 6'd21)
                begin
                    width_next[sh +: 8] = data_byte;
                end
                if (hp >= 6'd22 && hp <= 6'd25)
                begin
                    height_next[sh +: 8] = data_byte;
                end
                if (hp >= 6'd46 && hp <= 6'd49)
                begin
                    colors_next[sh +: 8] = data_byte;
                end
                if (hp == HDR_LAST_POS)
                begin
                    pos_next = HDR_BYTES;
                    if (judge != ST_OK)
                    begin
                        status_res.status = judge;
                        if (judge == ST_BAD_FMT || judge == ST_BAD_DIMS ||
                            judge == ST_TOO_LARGE)
                        begin
                            status_res.image_width  = '0;
                            status_res.image_height = '0;
                        end
                        push.count = 2'd1;
                        push.first = status_res;
                    end
                    else if (last)
                    begin
                        status_res.status = ST_TRUNC;
                        push.count = 2'd1;
                        push.first = status_res;
                    end
                end
                else
                begin
                    pos_next = pos_reg + 33'd1;
                    if (last)
                    begin
                        status_res.status       = ST_BAD_FMT;
                        status_res.image_width  = '0;
                        status_res.image_height = '0;
                        push.count = 2'd1;
                        push.first = status_res;
                    end
                end
            end
            PH_BODY:
            begin
                if (in_palette)
                begin
                    case (rel[1:0])
                        2'd0: held_blue_next = data_byte;
                        2'd1: held_green_next = data_byte;
                        2'd2:
                        begin
                            data_valid            = 1'b1;
                            data_res.kind         = KIND_PALETTE;
                            data_res.palette_slot = rel[9:2];
                            data_res.red          = data_byte;
                            data_res.green        = held_green_reg;
                            data_res.blue         = held_blue_reg;
                        end
                        default: data_valid = 1'b0;
                    endcase
                end
                else if (in_pixels)
                begin
                    if ({{(32 - CNT_W){1'b0}}, col_reg} < width_reg)
                    begin
                        data_valid           = 1'b1;
                        data_res.kind        = KIND_PIXEL;
                        data_res.x           = 26'(col_reg);
                        data_res.y           = y_val[25:0];
                        data_res.pixel_index = data_byte;
                    end
                    if ({{(32 - CNT_W){1'b0}}, col_inc} >= pitch_reg)
                    begin
                        col_next = '0;
                        row_next = row_reg + {{(CNT_W - 1){1'b0}}, 1'b1};
                    end
                    else
                    begin
                        col_next = col_inc[CNT_W-1:0];
                    end
                end
                pos_next = (pos_reg < POS_MAX) ? pos_reg + 33'd1 : POS_MAX;
                status_res.status = ({{(32 - CNT_W){1'b0}}, row_next} >= hm_reg)
                                    ? ST_OK : ST_TRUNC;
                data_res.run_last = !last;
                if (data_valid && last)
                begin
                    push.count  = 2'd2;
                    push.first  = data_res;
                    push.second = status_res;
                end
                else if (data_valid)
                begin
                    push.count = 2'd1;
                    push.first = data_res;
                end
                else if (last)
                begin
                    push.count = 2'd1;
                    push.first = status_res;
                end
            end
            PH_DRAIN:
            begin
                pos_next = pos_reg;
            end
            default: file_end = 1'b1;
        endcase

        if (file_end)
        begin
            pos_next      = '0;
            width_next    = '0;
            height_next   = '0;
            offset_next   = '0;
            colors_next   = '0;
            fmt_good_next = 1'b1;
            row_next      = '0;
            col_next      = '0;
        end

        if (!accept)
        begin
            push.count = 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_HEADER;
            pos_reg      <= '0;
            width_reg    <= '0;
            height_reg   <= '0;
            offset_reg   <= '0;
            colors_reg   <= '0;
            fmt_good_reg <= 1'b1;
            row_reg      <= '0;
            col_reg      <= '0;
        end
        else if (accept)
        begin
            phase_reg    <= phase_next;
            pos_reg      <= pos_next;
            width_reg    <= width_next;
            height_reg   <= height_next;
            offset_reg   <= offset_next;
            colors_reg   <= colors_next;
            fmt_good_reg <= fmt_good_next;
            row_reg      <= row_next;
            col_reg      <= col_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            held_blue_reg  <= held_blue_next;
            held_green_reg <= held_green_next;
        end
    end

endmodule

// File: rtl/core/ibsp_out_fifo.sv
// Result queue of the BMP parser: takes up to two results a cycle, gives one while ready.
// Signals room for a full byte's worth of results. Depends on ibsp_pkg.
module ibsp_out_fifo
    import ibsp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  push_t   push,
    output logic    room,
    output logic    valid,
    input  logic    ready,
    output result_t head
);

    result_t              mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [FIFO_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW:0]     count_reg, count_next;
    logic                 pop;
    logic [FIFO_AW-1:0]   wr_ptr_second;

    assign valid         = (count_reg != '0);
    assign pop           = valid && ready;
    assign room          = (count_reg <= (FIFO_AW + 1)'(FIFO_DEPTH - 2));
    assign head          = mem_reg[rd_ptr_reg];
    assign wr_ptr_second = wr_ptr_reg + {{(FIFO_AW - 1){1'b0}}, 1'b1};

    always_comb
    begin
        rd_ptr_next = rd_ptr_reg + {{(FIFO_AW - 1){1'b0}}, pop};
        wr_ptr_next = wr_ptr_reg + FIFO_AW'(push.count);
        count_next  = count_reg + (FIFO_AW + 1)'(push.count)
                      - {{FIFO_AW{1'b0}}, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            mem_reg[wr_ptr_second] <= push.second;
        end
    end

endmodule

// File: rtl/core/indexed_bmp_stream_parser_top.sv
// Indexed BMP stream parser, top level. Takes one file byte per cycle while the queue has room.
// A result is registered into the result queue and offered once the results ahead of it have gone.
// Throughput: one byte per cycle; a four-word result queue absorbs bytes that
// give two results, and input stalls only while the queue holds three or more.
// Reset (rst_n low, asynchronous) empties the queue and restarts at a new header.
// Depends on ibsp_pkg, ibsp_in_if, ibsp_out_if, ibsp_decode and ibsp_out_fifo.
module indexed_bmp_stream_parser_top
    import ibsp_pkg::*;
#(
    parameter int MAX_PIXELS      = 67108864,
    parameter int PALETTE_ENTRIES = 256
) (
    input logic        clk,
    input logic        rst_n,
    ibsp_in_if.sink    in_ch,
    ibsp_out_if.source out_ch
);

    push_t   push;
    result_t head;
    logic    room;
    logic    accept;

    assign in_ch.ready = room;
    assign accept      = in_ch.valid && room;

    ibsp_decode #(
        .MAX_PIXELS      (MAX_PIXELS),
        .PALETTE_ENTRIES (PALETTE_ENTRIES)
    ) u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .data_byte (in_ch.data_byte),
        .last      (in_ch.last),
        .push      (push)
    );

    ibsp_out_fifo u_out_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .room  (room),
        .valid (out_ch.valid),
        .ready (out_ch.ready),
        .head  (head)
    );

    assign out_ch.kind         = head.kind;
    assign out_ch.palette_slot = head.palette_slot;
    assign out_ch.red          = head.red;
    assign out_ch.green        = head.green;
    assign out_ch.blue         = head.blue;
    assign out_ch.x            = head.x;
    assign out_ch.y            = head.y;
    assign out_ch.pixel_index  = head.pixel_index;
    assign out_ch.status       = head.status;
    assign out_ch.image_width  = head.image_width;
    assign out_ch.image_height = head.image_height;
    assign out_ch.run_last     = head.run_last;

endmodule
